// ----- hw/rtl/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Shared transaction types, token and status codes, and character constants.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // Input transaction: one raw byte of the request buffer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } hrhp_in_t;

  // Output transaction: the byte with its tag and the parse results so far.
  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] token_kind;
    logic [1:0] parse_status;
    logic [1:0] method_code;
    logic [7:0] version_major;
    logic [7:0] version_minor;
    logic [7:0] header_count;
  } hrhp_out_t;

  // Token kinds.
  localparam logic [3:0] TK_METHOD   = 4'd0;
  localparam logic [3:0] TK_SEP      = 4'd1;
  localparam logic [3:0] TK_PATH     = 4'd2;
  localparam logic [3:0] TK_PROTO    = 4'd3;
  localparam logic [3:0] TK_MAJOR    = 4'd4;
  localparam logic [3:0] TK_MINOR    = 4'd5;
  localparam logic [3:0] TK_HNAME    = 4'd6;
  localparam logic [3:0] TK_HVALUE   = 4'd7;
  localparam logic [3:0] TK_LINE_END = 4'd8;
  localparam logic [3:0] TK_BODY     = 4'd9;

  // Parse status.
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Method codes.
  localparam logic [1:0] MC_NONE = 2'd0;
  localparam logic [1:0] MC_GET  = 2'd1;
  localparam logic [1:0] MC_POST = 2'd2;
  localparam logic [1:0] MC_PUT  = 2'd3;

  // Parser phases.
  localparam logic [3:0] PH_METHOD   = 4'd0;
  localparam logic [3:0] PH_PATH     = 4'd1;
  localparam logic [3:0] PH_PROTO    = 4'd2;
  localparam logic [3:0] PH_MAJOR    = 4'd3;
  localparam logic [3:0] PH_MINOR    = 4'd4;
  localparam logic [3:0] PH_RL_SKIP  = 4'd5;
  localparam logic [3:0] PH_HDR_FIRST = 4'd6;
  localparam logic [3:0] PH_HNAME    = 4'd7;
  localparam logic [3:0] PH_HVALUE   = 4'd8;
  localparam logic [3:0] PH_H_SKIP   = 4'd9;
  localparam logic [3:0] PH_HDR_NEXT = 4'd10;
  localparam logic [3:0] PH_FINISHED = 4'd11;

  // Characters and packed method words.
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [31:0] WORD_GET  = 32'h0047_4554;
  localparam logic [31:0] WORD_POST = 32'h504F_5354;
  localparam logic [31:0] WORD_PUT  = 32'h0050_5554;
  localparam logic [31:0] WORD_HTTP = 32'h4854_5450;

  // Expected protocol name character at a given position.
  function automatic logic [7:0] proto_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = WORD_HTTP[31:24];
      2'd1:    ch = WORD_HTTP[23:16];
      2'd2:    ch = WORD_HTTP[15:8];
      default: ch = WORD_HTTP[7:0];
    endcase
    return ch;
  endfunction

endpackage

// ----- hw/rtl/http_request_head_parser.sv -----
// ----------------------------------------------------------------------------
// HTTP request head parser
// Tags each byte of an HTTP/1.x request head and reports the parse results.
// ----------------------------------------------------------------------------
// Usage: bytes of a request buffer enter on the in_ channel, one per
// transaction, with first_byte marking the start of a new request and
// last_byte marking the end of the received buffer. Every input transaction
// produces exactly one output transaction on the out_ channel carrying the
// byte, its token kind and the status, method, version and header count as
// they stand after that byte.
// Path: an accepted byte is held in the input register, processed from
// there, and its result is written into the result register as soon as
// that register is free, from where it is shown on out_.
// Throughput: one byte per cycle while out_ is not stalled; the per-byte
// phase logic is short enough to sit between the input and result registers.
// Stall: when out_stall holds a valid result, the result stays put and the
// input register keeps its byte; in_stall rises only when the input register
// is full and cannot move forward, so one byte still gets in behind a waiting
// result.
// Reset: rst_n low empties both registers and returns the parser to the
// method phase with all counters and results cleared.
// ----------------------------------------------------------------------------
module http_request_head_parser
  import hrhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hrhp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output hrhp_out_t out_data
);

  // Pipeline registers and handshake.
  logic      in_valid_r;
  hrhp_in_t  in_data_r;
  logic      out_valid_r;
  hrhp_out_t out_data_r;
  logic      out_free;
  logic      proc_fire;

  // Parser state.
  logic [3:0]  phase_r,       phase_nxt;
  logic [31:0] method_chars_r, method_chars_nxt;
  logic [2:0]  method_len_r,  method_len_nxt;
  logic [2:0]  proto_cnt_r,   proto_cnt_nxt;
  logic        proto_bad_r,   proto_bad_nxt;
  logic [7:0]  major_r,       major_nxt;
  logic [7:0]  minor_r,       minor_nxt;
  logic        digit_seen_r,  digit_seen_nxt;
  logic        digit_stop_r,  digit_stop_nxt;
  logic [1:0]  method_r,      method_nxt;
  logic [7:0]  hdr_count_r,   hdr_count_nxt;
  logic [1:0]  status_r,      status_nxt;

  // State as seen by the current byte, after an optional restart.
  logic [3:0]  cur_phase;
  logic [31:0] cur_method_chars;
  logic [2:0]  cur_method_len;
  logic [2:0]  cur_proto_cnt;
  logic        cur_proto_bad;
  logic [7:0]  cur_major;
  logic [7:0]  cur_minor;
  logic        cur_digit_seen;
  logic        cur_digit_stop;
  logic [1:0]  cur_method;
  logic [7:0]  cur_hdr_count;
  logic [1:0]  cur_status;

  logic [7:0]  b;
  logic        b_is_eol;
  logic        b_is_digit;
  logic [7:0]  acc_sel;
  logic [11:0] acc_prod;
  logic [7:0]  acc_sat;
  logic [3:0]  kind;

  assign out_free  = !out_valid_r || !out_stall;
  assign proc_fire = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A first_byte restarts the parser before its byte is examined.
  always_comb begin
    if (in_data_r.first_byte) begin
      cur_phase        = PH_METHOD;
      cur_method_chars = '0;
      cur_method_len   = '0;
      cur_proto_cnt    = '0;
      cur_proto_bad    = 1'b0;
      cur_major        = '0;
      cur_minor        = '0;
      cur_digit_seen   = 1'b0;
      cur_digit_stop   = 1'b0;
      cur_method       = MC_NONE;
      cur_hdr_count    = '0;
      cur_status       = ST_MORE;
    end else begin
      cur_phase        = phase_r;
      cur_method_chars = method_chars_r;
      cur_method_len   = method_len_r;
      cur_proto_cnt    = proto_cnt_r;
      cur_proto_bad    = proto_bad_r;
      cur_major        = major_r;
      cur_minor        = minor_r;
      cur_digit_seen   = digit_seen_r;
      cur_digit_stop   = digit_stop_r;
      cur_method       = method_r;
      cur_hdr_count    = hdr_count_r;
      cur_status       = status_r;
    end
  end

  assign b          = in_data_r.data_byte;
  assign b_is_eol   = (b == CH_CR) || (b == CH_LF);
  assign b_is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // One shared decimal accumulator step for both version fields; the result
  // saturates at 255.
  assign acc_sel  = (cur_phase == PH_MINOR) ? cur_minor : cur_major;
  assign acc_prod = ({4'd0, acc_sel} * 12'd10) + {8'd0, b[3:0]};
  assign acc_sat  = (acc_prod > 12'd255) ? 8'hFF : acc_prod[7:0];

  always_comb begin
    phase_nxt        = cur_phase;
    method_chars_nxt = cur_method_chars;
    method_len_nxt   = cur_method_len;
    proto_cnt_nxt    = cur_proto_cnt;
    proto_bad_nxt    = cur_proto_bad;
    major_nxt        = cur_major;
    minor_nxt        = cur_minor;
    digit_seen_nxt   = cur_digit_seen;
    digit_stop_nxt   = cur_digit_stop;
    method_nxt       = cur_method;
    hdr_count_nxt    = cur_hdr_count;
    status_nxt       = cur_status;
    kind             = TK_BODY;

    unique case (cur_phase) inside
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          kind = TK_SEP;
          if (cur_method_len == 3'd3 && cur_method_chars == WORD_GET) begin
            method_nxt = MC_GET;
          end else if (cur_method_len == 3'd4 && cur_method_chars == WORD_POST) begin
            method_nxt = MC_POST;
          end else if (cur_method_len == 3'd3 && cur_method_chars == WORD_PUT) begin
            method_nxt = MC_PUT;
          end
          if (method_nxt == MC_NONE) begin
            status_nxt = ST_BAD;
            phase_nxt  = PH_FINISHED;
          end else begin
            phase_nxt = PH_PATH;
          end
        end else begin
          kind             = TK_METHOD;
          method_chars_nxt = {cur_method_chars[23:0], b};
          if (cur_method_len < 3'd5) begin
            method_len_nxt = cur_method_len + 3'd1;
          end
        end
      end
      PH_PATH: begin
        if (b == CH_SPACE) begin
          kind      = TK_SEP;
          phase_nxt = PH_PROTO;
        end else begin
          kind = TK_PATH;
        end
      end
      PH_PROTO: begin
        if (b == CH_SLASH) begin
          kind = TK_SEP;
          if (cur_proto_cnt != 3'd4 || cur_proto_bad) begin
            status_nxt = ST_BAD;
            phase_nxt  = PH_FINISHED;
          end else begin
            phase_nxt = PH_MAJOR;
          end
        end else begin
          kind = TK_PROTO;
          if (cur_proto_cnt >= 3'd4 || proto_char(cur_proto_cnt[1:0]) != b) begin
            proto_bad_nxt = 1'b1;
          end else begin
            proto_cnt_nxt = cur_proto_cnt + 3'd1;
          end
        end
      end
      PH_MAJOR: begin
        if (b == CH_DOT) begin
          kind = TK_SEP;
          if (!cur_digit_seen) begin
            status_nxt = ST_BAD;
            phase_nxt  = PH_FINISHED;
          end else begin
            phase_nxt      = PH_MINOR;
            digit_seen_nxt = 1'b0;
            digit_stop_nxt = 1'b0;
          end
        end else begin
          kind = TK_MAJOR;
          if (!cur_digit_stop) begin
            if (b_is_digit) begin
              major_nxt      = acc_sat;
              digit_seen_nxt = 1'b1;
            end else begin
              digit_stop_nxt = 1'b1;
            end
          end
        end
      end
      PH_MINOR: begin
        if (b_is_eol) begin
          kind = TK_LINE_END;
          if (!cur_digit_seen) begin
            status_nxt = ST_BAD;
            phase_nxt  = PH_FINISHED;
          end else begin
            phase_nxt = PH_RL_SKIP;
          end
        end else begin
          kind = TK_MINOR;
          if (!cur_digit_stop) begin
            if (b_is_digit) begin
              minor_nxt      = acc_sat;
              digit_seen_nxt = 1'b1;
            end else begin
              digit_stop_nxt = 1'b1;
            end
          end
        end
      end
      PH_RL_SKIP: begin
        kind      = TK_LINE_END;
        phase_nxt = PH_HDR_FIRST;
      end
      PH_H_SKIP: begin
        kind      = TK_LINE_END;
        phase_nxt = PH_HDR_NEXT;
      end
      PH_HDR_FIRST, PH_HDR_NEXT: begin
        if (b_is_eol) begin
          kind       = TK_LINE_END;
          status_nxt = (cur_phase == PH_HDR_FIRST) ? ST_BAD : ST_DONE;
          phase_nxt  = PH_FINISHED;
        end else if (b == CH_COLON) begin
          kind      = TK_SEP;
          phase_nxt = PH_HVALUE;
        end else begin
          kind      = TK_HNAME;
          phase_nxt = PH_HNAME;
        end
      end
      PH_HNAME: begin
        if (b == CH_COLON) begin
          kind      = TK_SEP;
          phase_nxt = PH_HVALUE;
        end else begin
          kind = TK_HNAME;
        end
      end
      PH_HVALUE: begin
        if (b_is_eol) begin
          kind = TK_LINE_END;
          if (cur_hdr_count != 8'hFF) begin
            hdr_count_nxt = cur_hdr_count + 8'd1;
          end
          phase_nxt = PH_H_SKIP;
        end else begin
          kind = TK_HVALUE;
        end
      end
      default: begin
        kind      = TK_BODY;
        phase_nxt = PH_FINISHED;
      end
    endcase

    // The end of the buffer settles a pending status: before the header
    // section it is a bad request, inside it the head counts as complete.
    if (in_data_r.last_byte && status_nxt == ST_MORE) begin
      status_nxt = (phase_nxt <= PH_HDR_FIRST) ? ST_BAD : ST_DONE;
      phase_nxt  = PH_FINISHED;
    end
  end

  // Handshake and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= PH_METHOD;
      method_chars_r <= '0;
      method_len_r   <= '0;
      proto_cnt_r    <= '0;
      proto_bad_r    <= 1'b0;
      major_r        <= '0;
      minor_r        <= '0;
      digit_seen_r   <= 1'b0;
      digit_stop_r   <= 1'b0;
      method_r       <= MC_NONE;
      hdr_count_r    <= '0;
      status_r       <= ST_MORE;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (proc_fire) begin
        in_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        phase_r        <= phase_nxt;
        method_chars_r <= method_chars_nxt;
        method_len_r   <= method_len_nxt;
        proto_cnt_r    <= proto_cnt_nxt;
        proto_bad_r    <= proto_bad_nxt;
        major_r        <= major_nxt;
        minor_r        <= minor_nxt;
        digit_seen_r   <= digit_seen_nxt;
        digit_stop_r   <= digit_stop_nxt;
        method_r       <= method_nxt;
        hdr_count_r    <= hdr_count_nxt;
        status_r       <= status_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (proc_fire) begin
      out_data_r.byte_out      <= b;
      out_data_r.token_kind    <= kind;
      out_data_r.parse_status  <= status_nxt;
      out_data_r.method_code   <= method_nxt;
      out_data_r.version_major <= major_nxt;
      out_data_r.version_minor <= minor_nxt;
      out_data_r.header_count  <= hdr_count_nxt;
    end
  end

endmodule

// ----- tb/http_head_tag_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request head tag checker
// Watches both channels of the head parser, predicts the tag and parse
// results of every accepted byte, and compares each result transaction with
// the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module http_head_tag_checker
  import hrhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  hrhp_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  hrhp_out_t out_data,
  output int        mismatch_count,
  output int        tags_pending
);

  logic [3:0]  phase;
  logic [31:0] method_word;
  logic [2:0]  method_len;
  logic [2:0]  proto_hits;
  logic        proto_bad;
  logic [7:0]  major_ver;
  logic [7:0]  minor_ver;
  logic        digit_seen;
  logic        digit_stop;
  logic [1:0]  method_code;
  logic [7:0]  header_lines;
  logic [1:0]  head_status;

  hrhp_out_t expected_tags[$];
  hrhp_out_t predicted;
  hrhp_out_t oldest;

  task automatic clear_parser();
    phase        = PH_METHOD;
    method_word  = '0;
    method_len   = '0;
    proto_hits   = '0;
    proto_bad    = 1'b0;
    major_ver    = '0;
    minor_ver    = '0;
    digit_seen   = 1'b0;
    digit_stop   = 1'b0;
    method_code  = MC_NONE;
    header_lines = '0;
    head_status  = ST_MORE;
  endtask

  task automatic close_head(input logic [1:0] st);
    head_status = st;
    phase       = PH_FINISHED;
  endtask

  // Only the leading run of digits counts; the first non-digit freezes it.
  task automatic take_digit(inout logic [7:0] acc, input logic [7:0] b);
    int v;
    if (!digit_stop) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        v = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
        acc = (v > 255) ? 8'd255 : 8'(v);
        digit_seen = 1'b1;
      end else begin
        digit_stop = 1'b1;
      end
    end
  endtask

  task automatic tag_byte(input hrhp_in_t item, output hrhp_out_t r);
    logic [7:0]  b;
    logic [3:0]  kind;
    logic        eol;
    logic [31:0] shifted;
    b    = item.data_byte;
    kind = TK_BODY;
    eol  = (b == CH_CR) || (b == CH_LF);
    if (item.first_byte) clear_parser();
    case (phase) inside
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          kind = TK_SEP;
          if (method_len == 3'd3 && method_word == WORD_GET) method_code = MC_GET;
          else if (method_len == 3'd4 && method_word == WORD_POST) method_code = MC_POST;
          else if (method_len == 3'd3 && method_word == WORD_PUT) method_code = MC_PUT;
          if (method_code == MC_NONE) close_head(ST_BAD);
          else phase = PH_PATH;
        end else begin
          kind = TK_METHOD;
          method_word = {method_word[23:0], b};
          if (method_len < 3'd5) method_len++;
        end
      end
      PH_PATH: begin
        if (b == CH_SPACE) begin
          kind  = TK_SEP;
          phase = PH_PROTO;
        end else begin
          kind = TK_PATH;
        end
      end
      PH_PROTO: begin
        if (b == CH_SLASH) begin
          kind = TK_SEP;
          if (proto_hits != 3'd4 || proto_bad) close_head(ST_BAD);
          else phase = PH_MAJOR;
        end else begin
          kind = TK_PROTO;
          shifted = WORD_HTTP << (8 * proto_hits[1:0]);
          if (proto_hits >= 3'd4 || shifted[31:24] != b) proto_bad = 1'b1;
          else proto_hits++;
        end
      end
      PH_MAJOR: begin
        if (b == CH_DOT) begin
          kind = TK_SEP;
          if (!digit_seen) begin
            close_head(ST_BAD);
          end else begin
            phase      = PH_MINOR;
            digit_seen = 1'b0;
            digit_stop = 1'b0;
          end
        end else begin
          kind = TK_MAJOR;
          take_digit(major_ver, b);
        end
      end
      PH_MINOR: begin
        if (eol) begin
          kind = TK_LINE_END;
          if (!digit_seen) close_head(ST_BAD);
          else phase = PH_RL_SKIP;
        end else begin
          kind = TK_MINOR;
          take_digit(minor_ver, b);
        end
      end
      PH_RL_SKIP, PH_H_SKIP: begin
        kind  = TK_LINE_END;
        phase = (phase == PH_RL_SKIP) ? PH_HDR_FIRST : PH_HDR_NEXT;
      end
      PH_HDR_FIRST, PH_HDR_NEXT: begin
        if (eol) begin
          kind = TK_LINE_END;
          close_head((phase == PH_HDR_FIRST) ? ST_BAD : ST_DONE);
        end else if (b == CH_COLON) begin
          kind  = TK_SEP;
          phase = PH_HVALUE;
        end else begin
          kind  = TK_HNAME;
          phase = PH_HNAME;
        end
      end
      PH_HNAME: begin
        if (b == CH_COLON) begin
          kind  = TK_SEP;
          phase = PH_HVALUE;
        end else begin
          kind = TK_HNAME;
        end
      end
      PH_HVALUE: begin
        if (eol) begin
          kind = TK_LINE_END;
          if (header_lines < 8'd255) header_lines++;
          phase = PH_H_SKIP;
        end else begin
          kind = TK_HVALUE;
        end
      end
      default: begin
        kind  = TK_BODY;
        phase = PH_FINISHED;
      end
    endcase
    // The buffer ran out: short of the headers is bad, inside them is done.
    if (item.last_byte && head_status == ST_MORE)
      close_head((phase <= PH_HDR_FIRST) ? ST_BAD : ST_DONE);
    r.byte_out      = b;
    r.token_kind    = kind;
    r.parse_status  = head_status;
    r.method_code   = method_code;
    r.version_major = major_ver;
    r.version_minor = minor_ver;
    r.header_count  = header_lines;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_tags.delete();
      mismatch_count = 0;
      tags_pending   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tags.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual byte %0d kind %0d",
                   $time, out_data.byte_out, out_data.token_kind);
        end else begin
          oldest = expected_tags.pop_front();
          check_field("byte_out", int'(oldest.byte_out), int'(out_data.byte_out));
          check_field("token_kind", int'(oldest.token_kind),
                      int'(out_data.token_kind));
          check_field("parse_status", int'(oldest.parse_status),
                      int'(out_data.parse_status));
          check_field("method_code", int'(oldest.method_code),
                      int'(out_data.method_code));
          check_field("version_major", int'(oldest.version_major),
                      int'(out_data.version_major));
          check_field("version_minor", int'(oldest.version_minor),
                      int'(out_data.version_minor));
          check_field("header_count", int'(oldest.header_count),
                      int'(out_data.header_count));
        end
      end
      if (in_valid && !in_stall) begin
        tag_byte(in_data, predicted);
        expected_tags.insert(expected_tags.size(), predicted);
      end
      tags_pending = expected_tags.size();
    end
  end

endmodule

// ----- tb/http_request_head_parser_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Feeds request buffers byte by byte into the parser, some well formed with
// random content, some broken, cut short or plain noise, while both channels
// idle and stall at varying rates. A checker beside the block predicts and
// compares every result; this module only makes stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module http_request_head_parser_test
  import hrhp_pkg::*;
();

  // Cycles without any accepted transaction before the run is declared hung.
  // It has to cover the long receiver hold-off below with ample margin.
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  hrhp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hrhp_out_t out_data;

  int mismatch_count;
  int tags_pending;

  // Traffic shaping knobs, changed between phases by the stimulus process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int bytes_sent     = 0;

  // The request currently being assembled, one byte per entry.
  logic [7:0] req_q[$];

  string      good_methods[3] = '{"GET", "POST", "PUT"};
  string      bad_methods[8]  = '{"", "GE", "GETS", "POSTX", "PUTPUT", "get", "XGET",
                                  "DELETE"};
  string      bad_protos[5]   = '{"", "HTT", "HTTPS", "http", "HTTX"};
  string      junk_chars      = " +-xaZ";
  logic [7:0] specials[6]     = '{CH_SPACE, CH_SLASH, CH_DOT, CH_COLON, CH_CR, CH_LF};

  http_request_head_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  http_head_tag_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .tags_pending   (tags_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side. A hold-off request from the stimulus process is taken over
  // into a local countdown; while it runs the receiver stalls every cycle so
  // the parser fills up and pushes back on its input. Otherwise the receiver
  // stalls at random with the current rate.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: any cycle in which neither channel moves a transaction counts
  // toward the limit; a single transaction on either side clears it.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[http_request_head_parser] ERROR");
          $finish;
        end
      end
    end
  end

  // Offers one byte, with random idle cycles in front of it at the current
  // rate. Called and returning at a falling edge; valid stays high from one
  // byte to the next when no idle cycle falls between them.
  task automatic push_byte(input logic [7:0] b, input logic first, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, first_byte: first, last_byte: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends the assembled request. Normally the first byte restarts the parser
  // and the final byte ends the buffer; noise gets its flags at random so
  // that restarts and buffer ends also land in the middle of a head.
  task automatic send_request(input bit scatter_flags);
    logic first;
    logic fin;
    for (int i = 0; i < req_q.size(); i++) begin
      if (scatter_flags) begin
        first = ($urandom_range(0, 9) == 0);
        fin   = ($urandom_range(0, 9) == 0);
      end else begin
        first = (i == 0);
        fin   = (i == req_q.size() - 1);
      end
      push_byte(req_q[i], first, fin);
    end
  endtask

  // Stops the sender until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tags_pending != 0) @(negedge clk);
  endtask

  // Appends one byte to the request being assembled.
  task automatic add_byte(input logic [7:0] b);
    req_q.insert(req_q.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] draw_byte(input logic [7:0] no1, input logic [7:0] no2,
                                           input logic [7:0] no3);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == no1 || b == no2 || b == no3);
    return b;
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  // The byte after a line end is skipped by the parser whatever it is.
  function automatic logic [7:0] skipped_byte();
    return ($urandom_range(0, 99) < 70) ? CH_LF : 8'($urandom_range(0, 255));
  endfunction

  // Version numbers: mostly one digit, sometimes long runs that saturate,
  // digits with trailing junk that must be ignored, leading junk or nothing
  // at all, both of which make the request bad at the terminator.
  task automatic add_version();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (r < 82) begin
      repeat ($urandom_range(2, 5)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (r < 88) begin
      add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      add_byte(junk_chars[$urandom_range(0, 5)]);
      add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (r < 94) begin
      add_byte(junk_chars[$urandom_range(0, 5)]);
      add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  // Builds a complete request head with random content: request line, zero
  // to four header lines, the empty line and a few body bytes. Occasionally
  // the method or protocol name is a wrong one.
  task automatic build_request();
    int len;
    int n_hdr;
    req_q.delete();
    if ($urandom_range(0, 99) < 90) add_text(good_methods[$urandom_range(0, 2)]);
    else add_text(bad_methods[$urandom_range(0, 7)]);
    add_byte(CH_SPACE);
    len = $urandom_range(0, 6);
    repeat (len) add_byte(draw_byte(CH_SPACE, CH_SPACE, CH_SPACE));
    add_byte(CH_SPACE);
    if ($urandom_range(0, 99) < 90) add_text("HTTP");
    else add_text(bad_protos[$urandom_range(0, 4)]);
    add_byte(CH_SLASH);
    add_version();
    add_byte(CH_DOT);
    add_version();
    add_byte(line_end());
    add_byte(skipped_byte());
    // No header at all means the empty line follows the request line at once.
    n_hdr = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 4);
    repeat (n_hdr) begin
      len = $urandom_range(0, 6);
      if (len > 0) begin
        add_byte(draw_byte(CH_CR, CH_LF, CH_COLON));
        repeat (len - 1) add_byte(draw_byte(CH_COLON, CH_COLON, CH_COLON));
      end
      add_byte(CH_COLON);
      len = $urandom_range(0, 8);
      repeat (len) add_byte(draw_byte(CH_CR, CH_LF, CH_LF));
      add_byte(line_end());
      add_byte(skipped_byte());
    end
    add_byte(line_end());
    add_byte(skipped_byte());
    len = $urandom_range(0, 4);
    repeat (len) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Random traffic up to a running byte total. Most requests are well formed
  // so the header and body phases are reached often; the rest get one byte
  // corrupted, are cut short, or are pure noise.
  task automatic random_requests(input int until_count);
    int r;
    int pos;
    int cut;
    while (bytes_sent < until_count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        req_q.delete();
        repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
        send_request(1'b1);
      end else begin
        build_request();
        if (r < 25) begin
          pos = $urandom_range(0, req_q.size() - 1);
          if ($urandom_range(0, 1)) req_q[pos] = specials[$urandom_range(0, 5)];
          else req_q[pos] = 8'($urandom_range(0, 255));
        end else if (r < 37) begin
          cut = $urandom_range(1, req_q.size());
          while (req_q.size() > cut) void'(req_q.pop_back());
        end
        send_request(1'b0);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A zero byte that is both first and last ends the buffer
    // in the method phase, which is bad.
    push_byte(8'h00, 1'b1, 1'b1);
    // An empty method is bad; the byte after it is tagged as ignored.
    push_byte(CH_SPACE, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // A minor version with no digit is bad at the line end.
    req_q.delete();
    add_text("PUT / HTTP/1.\n");
    send_request(1'b0);
    // The buffer ends inside the method.
    req_q.delete();
    add_text("GET");
    send_request(1'b0);
    drain();

    // Phase without idling. The receiver holds off for a long stretch while
    // the sender keeps offering, so the parser fills and stalls its input.
    // The first request carries enough header lines to saturate the count.
    hold_request = HOLD_OFF_CYCLES;
    req_q.delete();
    add_text("GET / HTTP/1.1");
    add_byte(CH_CR);
    add_byte(CH_LF);
    repeat (257) begin
      add_byte(CH_COLON);
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    add_byte(CH_CR);
    add_byte(CH_LF);
    send_request(1'b0);
    random_requests(900);
    drain();

    // Sender mostly idle.
    send_idle_pct  = 85;
    recv_stall_pct = 0;
    random_requests(1020);
    drain();

    // Receiver mostly stalling.
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    random_requests(1140);
    drain();

    // Both sides idle now and then.
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    random_requests(1260);
    drain();

    // Let a stray late result show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && tags_pending == 0) begin
      $display("[http_request_head_parser] OK");
    end else begin
      $display("[http_request_head_parser] ERROR");
    end
    $finish;
  end

endmodule

// ----- http_request_head_parser.f -----
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_head_parser.sv
tb/http_head_tag_checker.sv
tb/http_request_head_parser_test.sv
